>>> rtl/ett_pkg.sv
// Shared constants, codes and controller/datapath interface types of the timeout table.
package ett_pkg;

   localparam int OP_W      = 2;
   localparam int IDX_W     = 16;
   localparam int TIME_W    = 32;
   localparam int INTV_W    = 31;
   localparam int STATUS_W  = 3;

   localparam int DEPTH_DEF      = 64;
   localparam int INDEX_BITS_DEF = 16;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SET    = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EXP_ABS   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_EXP_REL   = 3'd6;
   localparam logic [STATUS_W-1:0] ST_NONE      = 3'd7;

   // scan modes
   localparam logic [1:0] SM_LOOKUP = 2'd0;
   localparam logic [1:0] SM_TICK   = 2'd1;
   localparam logic [1:0] SM_SELECT = 2'd2;

   // result kinds
   localparam logic [1:0] EK_RESULT = 2'd0;
   localparam logic [1:0] EK_NONE   = 2'd1;
   localparam logic [1:0] EK_EXPIRY = 2'd2;

   typedef struct packed {
      logic       load;
      logic       start;
      logic [1:0] mode;
      logic       commit;
      logic       emit;
      logic [1:0] kind;
   } cmd_type;

   typedef struct packed {
      logic req_tick;
      logic req_bad;
      logic scan_done;
      logic out_free;
      logic exp_any;
      logic exp_last;
   } sts_type;

endpackage

>>> rtl/ett_dpath.sv
// Datapath: entry memory, valid and expired flags, scan pipeline, result register.
module ett_dpath #(
   parameter int TABLE_DEPTH = ett_pkg::DEPTH_DEF,
   parameter int INDEX_BITS  = ett_pkg::INDEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ett_pkg::OP_W-1:0]      req_operation,
   input  logic [ett_pkg::IDX_W-1:0]     req_item_index,
   input  logic                          req_timeout_type,
   input  logic [ett_pkg::TIME_W-1:0]    req_timeout_value,
   input  logic [ett_pkg::TIME_W-1:0]    req_now_time,
   input  logic [ett_pkg::INTV_W-1:0]    req_interval,
   input  ett_pkg::cmd_type              cmd,
   output ett_pkg::sts_type              sts,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ett_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ett_pkg::IDX_W-1:0]     rsp_result_index,
   output logic                          rsp_last
);
   import ett_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
   localparam int EW = 1 + TIME_W + KW;

   logic [EW-1:0] mem [TABLE_DEPTH];
   logic [EW-1:0] rd_data_ff;

   logic [OP_W-1:0]     op_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                type_ff;
   logic [TIME_W-1:0]   value_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [INTV_W-1:0]   intv_ff;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0] exp_ff, exp_in;

   logic          run_ff;
   logic [CW-1:0] cnt_ff;
   logic [1:0]    mode_ff;
   logic          rd_act_ff;
   logic [AW-1:0] rd_slot_ff;

   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_slot_ff, hit_slot_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_slot_ff, free_slot_in;
   logic [EW-1:0] best_ff, best_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]    rsp_index_ff;
   logic                rsp_last_ff;

   logic                e_type;
   logic [TIME_W-1:0]   e_time;
   logic [KW-1:0]       e_key;
   logic                e_valid;
   logic                gone;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [EW-1:0]       wr_data;
   logic [TABLE_DEPTH-1:0] best_mask;

   assign e_type  = rd_data_ff[EW-1];
   assign e_time  = rd_data_ff[KW +: TIME_W];
   assign e_key   = rd_data_ff[KW-1:0];
   assign e_valid = valid_ff[rd_slot_ff];
   assign gone    = e_type ? (e_time <= {1'b0, intv_ff}) : (e_time <= now_ff);

   assign best_mask = TABLE_DEPTH'(1) << hit_slot_ff;

   assign sts.req_tick  = (req_operation == OP_TICK);
   assign sts.req_bad   = (req_item_index == '0) || ((req_item_index >> KW) != '0);
   assign sts.scan_done = !run_ff && !rd_act_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;
   assign sts.exp_any   = |exp_ff;
   assign sts.exp_last  = ((exp_ff & ~best_mask) == '0);

   always_comb begin
      valid_in     = valid_ff;
      exp_in       = exp_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      best_in      = best_ff;
      res_st_in    = res_st_ff;
      wr_en        = 1'b0;
      wr_addr      = rd_slot_ff;
      wr_data      = {type_ff, value_ff, idx_ff[KW-1:0]};

      if (cmd.start) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (rd_act_ff) begin
         unique case (mode_ff)
            SM_LOOKUP: begin
               if (e_valid && e_key == idx_ff[KW-1:0]) begin
                  hit_in      = 1'b1;
                  hit_slot_in = rd_slot_ff;
               end
               if (!e_valid && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = rd_slot_ff;
               end
            end
            SM_TICK: begin
               if (e_valid) begin
                  if (gone) begin
                     valid_in[rd_slot_ff] = 1'b0;
                     exp_in[rd_slot_ff]   = 1'b1;
                  end else if (e_type) begin
                     wr_en   = 1'b1;
                     wr_data = {e_type, e_time - {1'b0, intv_ff}, e_key};
                  end
               end
            end
            SM_SELECT: begin
               if (exp_ff[rd_slot_ff] && (!hit_ff || rd_data_ff < best_ff)) begin
                  hit_in      = 1'b1;
                  hit_slot_in = rd_slot_ff;
                  best_in     = rd_data_ff;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         res_st_in = ST_BAD_INDEX;
      end

      if (cmd.commit) begin
         unique case (op_ff)
            OP_REMOVE: begin
               if (hit_ff) valid_in[hit_slot_ff] = 1'b0;
               res_st_in = ST_REMOVED;
            end
            OP_SET: begin
               if (hit_ff) begin
                  // freed slot may be lower than any other free slot
                  valid_in[hit_slot_ff] = 1'b0;
                  wr_en   = 1'b1;
                  wr_addr = (free_ff && free_slot_ff < hit_slot_ff) ? free_slot_ff : hit_slot_ff;
                  valid_in[wr_addr] = 1'b1;
                  res_st_in = ST_ACCEPTED;
               end else if (free_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = free_slot_ff;
                  valid_in[free_slot_ff] = 1'b1;
                  res_st_in = ST_ACCEPTED;
               end else begin
                  res_st_in = ST_FULL;
               end
            end
            default: begin
               if (hit_ff) begin
                  res_st_in = ST_DUPLICATE;
               end else if (free_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = free_slot_ff;
                  valid_in[free_slot_ff] = 1'b1;
                  res_st_in = ST_ACCEPTED;
               end else begin
                  res_st_in = ST_FULL;
               end
            end
         endcase
      end

      if (cmd.emit && cmd.kind == EK_EXPIRY) begin
         exp_in[hit_slot_ff] = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (run_ff) rd_data_ff <= mem[cnt_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         exp_ff       <= '0;
         run_ff       <= 1'b0;
         rd_act_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         exp_ff       <= exp_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_act_ff    <= run_ff;
         if (cmd.start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == CW'(TABLE_DEPTH - 1)) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_slot_ff  <= hit_slot_in;
      free_slot_ff <= free_slot_in;
      best_ff      <= best_in;
      res_st_ff    <= res_st_in;
      rd_slot_ff   <= cnt_ff[AW-1:0];
      if (cmd.start) begin
         cnt_ff  <= '0;
         mode_ff <= cmd.mode;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.load) begin
         op_ff    <= req_operation;
         idx_ff   <= req_item_index;
         type_ff  <= req_timeout_type;
         value_ff <= req_timeout_value;
         now_ff   <= req_now_time;
         intv_ff  <= req_interval;
      end
      if (cmd.emit) begin
         case (cmd.kind)
            EK_NONE: begin
               rsp_status_ff <= ST_NONE;
               rsp_index_ff  <= '0;
               rsp_last_ff   <= 1'b1;
            end
            EK_EXPIRY: begin
               rsp_status_ff <= best_ff[EW-1] ? ST_EXP_REL : ST_EXP_ABS;
               rsp_index_ff  <= IDX_W'(best_ff[KW-1:0]);
               rsp_last_ff   <= sts.exp_last;
            end
            default: begin
               rsp_status_ff <= res_st_ff;
               rsp_index_ff  <= idx_ff;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> rtl/ett_ctrl.sv
// Controller: sequences lookup, commit, tick and expiry-selection scans.
module ett_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output ett_pkg::cmd_type  cmd,
   input  ett_pkg::sts_type  sts
);
   import ett_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOOK   = 4'd1;
   localparam logic [3:0] S_COMMIT = 4'd2;
   localparam logic [3:0] S_REPLY  = 4'd3;
   localparam logic [3:0] S_TICK   = 4'd4;
   localparam logic [3:0] S_CHECK  = 4'd5;
   localparam logic [3:0] S_SEL    = 4'd6;
   localparam logic [3:0] S_EXP    = 4'd7;
   localparam logic [3:0] S_NONE   = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.req_tick) begin
                  cmd.start = 1'b1;
                  cmd.mode  = SM_TICK;
                  state_in  = S_TICK;
               end else if (sts.req_bad) begin
                  state_in = S_REPLY;
               end else begin
                  cmd.start = 1'b1;
                  cmd.mode  = SM_LOOKUP;
                  state_in  = S_LOOK;
               end
            end
         end
         S_LOOK: if (sts.scan_done) state_in = S_COMMIT;
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_REPLY;
         end
         S_REPLY: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EK_RESULT;
               state_in = S_IDLE;
            end
         end
         S_TICK: if (sts.scan_done) state_in = S_CHECK;
         S_CHECK: begin
            if (sts.exp_any) begin
               cmd.start = 1'b1;
               cmd.mode  = SM_SELECT;
               state_in  = S_SEL;
            end else begin
               state_in = S_NONE;
            end
         end
         S_SEL: if (sts.scan_done) state_in = S_EXP;
         S_EXP: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EK_EXPIRY;
               state_in = sts.exp_last ? S_IDLE : S_CHECK;
            end
         end
         S_NONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EK_NONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/expiry_timeout_table.sv
// Top level of the expiry timeout table.
// Add, remove and set with a valid index each scan the whole table once to find
// the key and the lowest free slot; a bad index is answered without a scan. A
// tick scans the table once to count relative entries down and mark expiries.
// It then makes one further full scan per expired entry to pick the next one in
// (type, time, index) order; a tick with nothing due still answers. The scans
// read one table entry per cycle. A new request is taken only when the previous
// one has put its last result beat into the output register; that beat may
// still wait there.
module expiry_timeout_table #(
   parameter int TABLE_DEPTH = ett_pkg::DEPTH_DEF,
   parameter int INDEX_BITS  = ett_pkg::INDEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ett_pkg::OP_W-1:0]      req_operation,
   input  logic [ett_pkg::IDX_W-1:0]     req_item_index,
   input  logic                          req_timeout_type,
   input  logic [ett_pkg::TIME_W-1:0]    req_timeout_value,
   input  logic [ett_pkg::TIME_W-1:0]    req_now_time,
   input  logic [ett_pkg::INTV_W-1:0]    req_interval,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ett_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ett_pkg::IDX_W-1:0]     rsp_result_index,
   output logic                          rsp_last
);
   import ett_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ett_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ett_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX_BITS  (INDEX_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_item_index    (req_item_index),
      .req_timeout_type  (req_timeout_type),
      .req_timeout_value (req_timeout_value),
      .req_now_time      (req_now_time),
      .req_interval      (req_interval),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_index  (rsp_result_index),
      .rsp_last          (rsp_last)
   );

endmodule

>>> rtl/ett_checker.sv
// Port-level checker for the expiry timeout table, bound to the top level.
module ett_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [ett_pkg::OP_W-1:0]      req_operation,
   input logic [ett_pkg::IDX_W-1:0]     req_item_index,
   input logic                          req_timeout_type,
   input logic [ett_pkg::TIME_W-1:0]    req_timeout_value,
   input logic [ett_pkg::TIME_W-1:0]    req_now_time,
   input logic [ett_pkg::INTV_W-1:0]    req_interval,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ett_pkg::STATUS_W-1:0]  rsp_status,
   input logic [ett_pkg::IDX_W-1:0]     rsp_result_index,
   input logic                          rsp_last
);
   import ett_pkg::*;

   // a waiting result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a request keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken back to back");

   a_none_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NONE |-> rsp_last && rsp_result_index == '0)
      else $error("empty tick beat malformed");

   a_cmd_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_EXP_ABS && rsp_status != ST_EXP_REL |-> rsp_last)
      else $error("command result not marked last");

endmodule

bind expiry_timeout_table ett_checker u_ett_checker (.*);

>>> sim/testbench.sv
// Self-checking testbench for the expiry timeout table: predictor scoreboard plus random traffic.
import ett_pkg::*;

class timeout_scoreboard;
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index;
      logic                last;
   } result_beat;

   typedef struct {
      logic              rel;
      logic [TIME_W-1:0] tval;
      logic [IDX_W-1:0]  key;
   } expiry_entry;

   bit                entry_valid[DEPTH_DEF];
   logic              entry_rel[DEPTH_DEF];
   logic [IDX_W-1:0]  entry_key[DEPTH_DEF];
   logic [TIME_W-1:0] entry_time[DEPTH_DEF];
   result_beat        expected_beats[$];
   int                errors;

   function new();
      errors = 0;
      foreach (entry_valid[i]) entry_valid[i] = 0;
   endfunction

   function int find_key(logic [IDX_W-1:0] key);
      foreach (entry_valid[i])
         if (entry_valid[i] && entry_key[i] == key) return i;
      return -1;
   endfunction

   function logic [STATUS_W-1:0] insert_key(logic [IDX_W-1:0] key, logic rel,
                                            logic [TIME_W-1:0] tval);
      if (find_key(key) >= 0) return ST_DUPLICATE;
      foreach (entry_valid[i])
         if (!entry_valid[i]) begin
            entry_valid[i] = 1;
            entry_rel[i] = rel;
            entry_key[i] = key;
            entry_time[i] = tval;
            return ST_ACCEPTED;
         end
      return ST_FULL;
   endfunction

   function void drop_key(logic [IDX_W-1:0] key);
      int s;
      s = find_key(key);
      if (s >= 0) entry_valid[s] = 0;
   endfunction

   function bit goes_first(expiry_entry a, expiry_entry b);
      if (a.rel != b.rel) return a.rel < b.rel;
      if (a.tval != b.tval) return a.tval < b.tval;
      return a.key < b.key;
   endfunction

   // input beat accepted: work out its results
   function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] key, logic rel,
                              logic [TIME_W-1:0] tval, logic [TIME_W-1:0] now,
                              logic [INTV_W-1:0] intv);
      result_beat    b;
      expiry_entry   gone[$];
      expiry_entry   e;
      bit            hit;
      int            j;
      logic [TIME_W-1:0] intv32;
      if (op != OP_TICK) begin
         b.index = key;
         b.last = 1;
         if (key == 0) b.status = ST_BAD_INDEX;
         else if (op == OP_ADD) b.status = insert_key(key, rel, tval);
         else if (op == OP_REMOVE) begin
            drop_key(key);
            b.status = ST_REMOVED;
         end else begin
            drop_key(key);
            b.status = insert_key(key, rel, tval);
         end
         expected_beats.push_back(b);
         return;
      end
      intv32 = {1'b0, intv};
      foreach (entry_valid[i]) begin
         if (!entry_valid[i]) continue;
         if (!entry_rel[i]) hit = entry_time[i] <= now;
         else begin
            hit = entry_time[i] <= intv32;
            if (!hit) entry_time[i] = entry_time[i] - intv32;
         end
         if (hit) begin
            e.rel = entry_rel[i];
            e.tval = entry_time[i];
            e.key = entry_key[i];
            entry_valid[i] = 0;
            j = 0;
            while (j < gone.size() && !goes_first(e, gone[j])) j++;
            gone.insert(j, e);
         end
      end
      if (gone.size() == 0) begin
         b.status = ST_NONE;
         b.index = 0;
         b.last = 1;
         expected_beats.push_back(b);
         return;
      end
      foreach (gone[i]) begin
         b.status = gone[i].rel ? ST_EXP_REL : ST_EXP_ABS;
         b.index = gone[i].key;
         b.last = (i == gone.size() - 1);
         expected_beats.push_back(b);
      end
   endfunction

   function void check_result(logic [STATUS_W-1:0] status, logic [IDX_W-1:0] index,
                              logic last);
      result_beat b;
      if (expected_beats.size() == 0) begin
         $error("unexpected result beat: status %0d index %0d last %0d",
                status, index, last);
         errors++;
         return;
      end
      b = expected_beats.pop_front();
      if (status !== b.status) begin
         $error("status: expected %0d, got %0d", b.status, status);
         errors++;
      end
      if (index !== b.index) begin
         $error("result_index: expected %0d, got %0d", b.index, index);
         errors++;
      end
      if (last !== b.last) begin
         $error("last: expected %0d, got %0d", b.last, last);
         errors++;
      end
   endfunction
endclass

module testbench;
   localparam int IDLE_LIMIT = 20000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation;
   logic [IDX_W-1:0]    req_item_index;
   logic                req_timeout_type;
   logic [TIME_W-1:0]   req_timeout_value;
   logic [TIME_W-1:0]   req_now_time;
   logic [INTV_W-1:0]   req_interval;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_result_index;
   logic                rsp_last;

   timeout_scoreboard sb = new();
   int  results_seen = 0;
   int  idle_cycles = 0;
   bit  hold_done = 0;

   expiry_timeout_table DUT (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_beat(logic [OP_W-1:0] op, logic [IDX_W-1:0] key, logic rel,
                            logic [TIME_W-1:0] tval, logic [TIME_W-1:0] now,
                            logic [INTV_W-1:0] intv, bit idle_ok = 1);
      int gap;
      gap = idle_ok ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_operation <= op;
      req_item_index <= key;
      req_timeout_type <= rel;
      req_timeout_value <= tval;
      req_now_time <= now;
      req_interval <= intv;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, key, rel, tval, now, intv);
   endtask

   function automatic logic [IDX_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return IDX_W'($urandom_range(1, 90));
      if (r < 88) return '0;
      return IDX_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [TIME_W-1:0] pick_time(int span);
      return ($urandom_range(0, 99) < 85) ? $urandom_range(0, span) : $urandom;
   endfunction

   // result side: random stalls, one long hold-off, checking and the watchdog
   initial begin
      int stall_left;
      bit calm;
      stall_left = 0;
      calm = 0;
      rsp_stall <= 1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_status, rsp_result_index, rsp_last);
            results_seen++;
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
         if (!hold_done && results_seen == 150) begin
            hold_done = 1;
            stall_left = 600;   // long hold-off: input must back up
         end else if (stall_left == 0) begin
            if ($urandom_range(0, 199) == 0) calm = ~calm;
            if (!calm && $urandom_range(0, 99) < 30)
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                        : $urandom_range(1, 3);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1;
            stall_left--;
         end else rsp_stall <= 0;
         @(posedge clock);
      end
   end

   initial begin
      int r;
      reset <= 1;
      req_valid <= 0;
      req_operation <= OP_ADD;
      req_item_index <= 0;
      req_timeout_type <= 0;
      req_timeout_value <= 0;
      req_now_time <= 0;
      req_interval <= 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed corners
      send_beat(OP_ADD, 0, 0, 5, 0, 0);
      send_beat(OP_REMOVE, 0, 1, 5, 0, 0);
      send_beat(OP_SET, 0, 1, 5, 0, 0);
      send_beat(OP_ADD, 16'hFFFF, 0, 32'hFFFF_FFFF, 0, 0);
      send_beat(OP_ADD, 16'hFFFF, 1, 3, 0, 0);             // duplicate, other type
      send_beat(OP_ADD, 1, 1, 0, 0, 0);
      send_beat(OP_ADD, 2, 1, 10, 0, 0);
      send_beat(OP_ADD, 3, 0, 0, 0, 0);
      send_beat(OP_ADD, 4, 0, 7, 0, 0);
      send_beat(OP_TICK, 0, 0, 0, 0, 0);                   // zero interval
      send_beat(OP_TICK, 0, 0, 0, 3, 0);                   // nothing due
      send_beat(OP_REMOVE, 77, 0, 0, 0, 0);                // absent
      send_beat(OP_REMOVE, 2, 0, 0, 0, 0);                 // type ignored
      send_beat(OP_SET, 4, 1, 20, 0, 0);
      send_beat(OP_SET, 5, 1, 20, 0, 0);
      send_beat(OP_ADD, 6, 1, 20, 0, 0);
      send_beat(OP_TICK, 0, 0, 0, 0, 5);
      send_beat(OP_TICK, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      send_beat(OP_ADD, 8, 1, 32'hFFFF_FFFF, 0, 0);
      send_beat(OP_TICK, 0, 0, 0, 0, 31'h7FFF_FFFF);       // remainder kept
      send_beat(OP_TICK, 0, 0, 0, 0, 31'h7FFF_FFFF);

      // fill the table, overflow it, then drain it in one tick
      for (int k = 0; k < 66; k++)
         send_beat(OP_ADD, IDX_W'(1000 + k), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 200), 0, 0, k % 4 == 0);
      send_beat(OP_SET, 2000, 0, 1, 0, 0);
      send_beat(OP_TICK, 0, 0, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);

      // random traffic
      for (int k = 0; k < 220; k++) begin
         r = $urandom_range(0, 99);
         if (r < 35)
            send_beat(OP_ADD, pick_key(), 1'($urandom_range(0, 1)), pick_time(2000),
                      $urandom, INTV_W'($urandom));
         else if (r < 50)
            send_beat(OP_REMOVE, pick_key(), 1'($urandom_range(0, 1)), $urandom,
                      $urandom, INTV_W'($urandom));
         else if (r < 70)
            send_beat(OP_SET, pick_key(), 1'($urandom_range(0, 1)), pick_time(2000),
                      $urandom, INTV_W'($urandom));
         else
            send_beat(OP_TICK, IDX_W'($urandom), 1'($urandom_range(0, 1)), $urandom,
                      pick_time(1500), INTV_W'(pick_time(300)));
      end
      req_valid <= 0;

      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.expected_beats.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
